[design/ppfs_pkg.sv]
// Shared types, constants and helper functions for the packed pixel fade scaler.
package ppfs_pkg;

  localparam int unsigned FADE_STEPS = 64;
  localparam int unsigned STEP_W     = $clog2(FADE_STEPS);
  localparam int unsigned K_W        = STEP_W + 1;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned OFF_W      = 5;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned BPP_W      = 3;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [BPP_W-1:0] BPP_16 = 3'd2;
  localparam logic [BPP_W-1:0] BPP_24 = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_OFF   = 3'd0,
    REG_RED_LEN   = 3'd1,
    REG_GREEN_OFF = 3'd2,
    REG_GREEN_LEN = 3'd3,
    REG_BLUE_OFF  = 3'd4,
    REG_BLUE_LEN  = 3'd5,
    REG_BPP       = 3'd6,
    REG_FADE_OUT  = 3'd7
  } reg_idx_e;

  // channel 0 red, 1 green, 2 blue
  typedef struct packed {
    logic [NUM_CH-1:0][OFF_W-1:0] offset;
    logic [NUM_CH-1:0][LEN_W-1:0] length;
    logic [BPP_W-1:0]             bpp;
    logic                         fade_out;
  } cfg_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(CH_W)) ? LEN_W'(CH_W) : len;
  endfunction

  function automatic logic [PIX_W-1:0] pix_mask(input logic [BPP_W-1:0] bpp);
    logic [PIX_W-1:0] m;
    case (bpp)
      BPP_16:  m = 32'h0000_ffff;
      BPP_24:  m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

[design/packed_pixel_fade_scaler_core.sv]
// Top level: config registers and the three-stage pixel fade pipeline.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: pixel_in[31:0], fade_step[37:32]
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: pixel_out[31:0]
//  cfg       in   cfg_we_i (always taken)      cfg_idx_i, cfg_data_i
//
// An item taken from s_axis passes in order through the unpack, multiply and repack
// register stages before it is valid on m_axis; one item per cycle sustained while m_axis is ready.
// Reset loads the register defaults (5:6:5 at 16 bpp, fade in) and empties the pipe.
// Each stage holds its item while the next is full, so a stall on m_axis
// backs up stage by stage; s_axis_tready drops only when all three are full.
module packed_pixel_fade_scaler_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // pixel_in[31:0], fade_step[37:32]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // pixel_out[31:0]
  input  logic                           cfg_we_i,
  input  logic [ppfs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppfs_pkg::CFG_W-1:0]     cfg_data_i
);
  import ppfs_pkg::*;

  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  cfg_t                        cfg_q;
  logic                        v1, r1, v2, r2;
  logic [NUM_CH-1:0][CH_W-1:0] chan1, chan2;
  logic [K_W-1:0]              k1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset[CH_RED]   <= OFF_W'(11);
      cfg_q.length[CH_RED]   <= LEN_W'(5);
      cfg_q.offset[CH_GREEN] <= OFF_W'(5);
      cfg_q.length[CH_GREEN] <= LEN_W'(6);
      cfg_q.offset[CH_BLUE]  <= OFF_W'(0);
      cfg_q.length[CH_BLUE]  <= LEN_W'(5);
      cfg_q.bpp              <= BPP_16;
      cfg_q.fade_out         <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RED_OFF:   cfg_q.offset[CH_RED]   <= cfg_data_i[OFF_W-1:0];
        REG_RED_LEN:   cfg_q.length[CH_RED]   <= cfg_data_i[LEN_W-1:0];
        REG_GREEN_OFF: cfg_q.offset[CH_GREEN] <= cfg_data_i[OFF_W-1:0];
        REG_GREEN_LEN: cfg_q.length[CH_GREEN] <= cfg_data_i[LEN_W-1:0];
        REG_BLUE_OFF:  cfg_q.offset[CH_BLUE]  <= cfg_data_i[OFF_W-1:0];
        REG_BLUE_LEN:  cfg_q.length[CH_BLUE]  <= cfg_data_i[LEN_W-1:0];
        REG_BPP:       cfg_q.bpp              <= cfg_data_i[BPP_W-1:0];
        REG_FADE_OUT:  cfg_q.fade_out         <= cfg_data_i[0];
        default:       cfg_q                  <= cfg_q;
      endcase
    end
  end

  ppfs_unpack u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_pixel_i  (s_axis_tdata[PIX_W-1:0]),
    .in_step_i   (s_axis_tdata[PIX_W+STEP_W-1:PIX_W]),
    .out_valid_o (v1),
    .out_ready_i (r1),
    .out_chan_o  (chan1),
    .out_k_o     (k1)
  );

  ppfs_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1),
    .in_ready_o  (r1),
    .in_chan_i   (chan1),
    .in_k_i      (k1),
    .out_valid_o (v2),
    .out_ready_i (r2),
    .out_chan_o  (chan2)
  );

  ppfs_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (v2),
    .in_ready_o  (r2),
    .in_chan_i   (chan2),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata)
  );

  // input backpressure only when every stage holds an item
  a_full_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1 && v2 && m_axis_tvalid))
    else $error("input stalled with a free pipeline stage");

  a_s2_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v2) |-> $past(v1))
    else $error("scale stage filled without an item from unpack");

  a_out_from_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(v2))
    else $error("output filled without an item from scale");

endmodule

[design/ppfs_unpack.sv]
// Stage 1: size mask, channel extraction with left alignment, fade factor.
module ppfs_unpack (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  ppfs_pkg::cfg_t                           cfg_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [ppfs_pkg::PIX_W-1:0]               in_pixel_i,
  input  logic [ppfs_pkg::STEP_W-1:0]              in_step_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [ppfs_pkg::NUM_CH-1:0][ppfs_pkg::CH_W-1:0] out_chan_o,
  output logic [ppfs_pkg::K_W-1:0]                 out_k_o
);
  import ppfs_pkg::*;

  logic                            valid_q;
  logic [NUM_CH-1:0][CH_W-1:0]     chan_d, chan_q;
  logic [K_W-1:0]                  k_d, k_q;
  logic [PIX_W-1:0]                pix_m;
  logic [NUM_CH-1:0][PIX_W-1:0]    sh;
  logic [NUM_CH-1:0][LEN_W-1:0]    len;
  logic [NUM_CH-1:0][CH_W:0]       one_sh;
  logic [NUM_CH-1:0][CH_W-1:0]     fld;
  logic [STEP_W-1:0]               step_c;
  logic                            adv;

  assign adv        = !valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    pix_m = in_pixel_i & pix_mask(cfg_i.bpp);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sh[ch]     = pix_m >> cfg_i.offset[ch];
      len[ch]    = clamp_len(cfg_i.length[ch]);
      one_sh[ch] = (CH_W+1)'(1) << len[ch];
      fld[ch]    = sh[ch][CH_W-1:0] & CH_W'(one_sh[ch] - (CH_W+1)'(1));
      // left-align; a zero-length field is already zero
      chan_d[ch] = CH_W'(fld[ch] << (LEN_W'(CH_W) - len[ch]));
    end
    step_c = (in_step_i > STEP_W'(FADE_STEPS - 1)) ? STEP_W'(FADE_STEPS - 1) : in_step_i;
    k_d    = cfg_i.fade_out ? (K_W'(FADE_STEPS - 1) - K_W'(step_c))
                            : (K_W'(step_c) + K_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      chan_q <= chan_d;
      k_q    <= k_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_chan_o  = chan_q;
  assign out_k_o     = k_q;

endmodule

[design/ppfs_scale.sv]
// Stage 2: per-channel multiply by the fade factor and divide by the step count.
module ppfs_scale (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            in_valid_i,
  output logic                                            in_ready_o,
  input  logic [ppfs_pkg::NUM_CH-1:0][ppfs_pkg::CH_W-1:0] in_chan_i,
  input  logic [ppfs_pkg::K_W-1:0]                        in_k_i,
  output logic                                            out_valid_o,
  input  logic                                            out_ready_i,
  output logic [ppfs_pkg::NUM_CH-1:0][ppfs_pkg::CH_W-1:0] out_chan_o
);
  import ppfs_pkg::*;

  localparam int unsigned PROD_W = K_W + CH_W;

  logic                          valid_q;
  logic [NUM_CH-1:0][PROD_W-1:0] prod;
  logic [NUM_CH-1:0][CH_W-1:0]   chan_d, chan_q;
  logic                          adv;

  assign adv        = !valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch]   = PROD_W'(in_k_i) * PROD_W'(in_chan_i[ch]);
      // k never exceeds FADE_STEPS, so the quotient fits a channel
      chan_d[ch] = CH_W'(prod[ch] >> STEP_W);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      chan_q <= chan_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_chan_o  = chan_q;

endmodule

[design/ppfs_pack.sv]
// Stage 3: shift back to field length in 16-bit mode, repack and output register.
module ppfs_pack (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  ppfs_pkg::cfg_t                                  cfg_i,
  input  logic                                            in_valid_i,
  output logic                                            in_ready_o,
  input  logic [ppfs_pkg::NUM_CH-1:0][ppfs_pkg::CH_W-1:0] in_chan_i,
  output logic                                            out_valid_o,
  input  logic                                            out_ready_i,
  output logic [ppfs_pkg::PIX_W-1:0]                      out_pixel_o
);
  import ppfs_pkg::*;

  localparam int unsigned WIDE_W = PIX_W + CH_W;

  logic                          valid_q;
  logic [PIX_W-1:0]              pix_d, pix_q;
  logic [NUM_CH-1:0][CH_W-1:0]   vn;
  logic [NUM_CH-1:0][WIDE_W-1:0] wide;
  logic [PIX_W-1:0]              acc;
  logic                          narrow;
  logic                          adv;

  assign adv        = !valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign narrow     = (cfg_i.bpp == BPP_16);

  always_comb begin
    acc = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      vn[ch]   = narrow ? (in_chan_i[ch] >> (LEN_W'(CH_W) - clamp_len(cfg_i.length[ch])))
                        : in_chan_i[ch];
      // bits pushed past the top of the pixel drop out
      wide[ch] = WIDE_W'(vn[ch]) << cfg_i.offset[ch];
      acc      = acc | wide[ch][PIX_W-1:0];
    end
    pix_d = acc & pix_mask(cfg_i.bpp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      pix_q <= pix_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_pixel_o = pix_q;

endmodule
